// ===== rtl/clnws_pkg.sv =====
// Package for the character LCD nibble write sequencer.
// Request codes, job descriptor type, port bit masks and hold constants.
// No dependencies.
`timescale 1ns / 1ps

package clnws_pkg;

    localparam logic [2:0] REQ_DATA   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_CURSOR = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_INIT   = 3'd4;

    localparam logic [7:0] NIBBLE_MASK    = 8'hF0;
    localparam logic [7:0] LOW_KEEP       = 8'h0F;
    localparam logic [7:0] RS_BIT         = 8'h01;
    localparam logic [7:0] E_BIT          = 8'h04;
    localparam logic [7:0] CMD_CLEAR_BYTE = 8'h01;

    localparam logic [15:0] HOLD_NONE  = 16'd0;
    localparam logic [15:0] HOLD_BYTE  = 16'd1000;
    localparam logic [15:0] HOLD_CLEAR = 16'd3000;
    localparam logic [15:0] HOLD_LEAD  = 16'd40000;
    localparam logic [15:0] HOLD_E     = 16'd100;

    typedef struct packed {
        logic       is_init;
        logic       is_data;
        logic       is_clear;
        logic [7:0] value;
    } t_job;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    init_byte = 8'h28;
            2'd1:    init_byte = 8'h0C;
            2'd2:    init_byte = 8'h01;
            default: init_byte = 8'h06;
        endcase
    endfunction

    function automatic logic [7:0] init_nibble(input logic [1:0] idx);
        init_nibble = (idx == 2'd3) ? 8'h20 : 8'h30;
    endfunction

    function automatic logic [15:0] init_pulse_tail(input logic [1:0] idx);
        case (idx)
            2'd0:    init_pulse_tail = 16'd6100;
            2'd1:    init_pulse_tail = 16'd400;
            default: init_pulse_tail = 16'd2100;
        endcase
    endfunction

endpackage

// ===== rtl/clnws_front.sv =====
// Front stage: accepts request words, drops unknown codes, builds job descriptors.
// Depends on clnws_pkg.
`timescale 1ns / 1ps

module clnws_front
    import clnws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_row,
    input  logic [7:0] i_col,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic known;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        known = 1'b1;
        n_job = '0;
        case (i_command)
            REQ_DATA: begin
                n_job.is_data = 1'b1;
                n_job.value   = i_byte_value;
            end
            REQ_CMD: begin
                n_job.value = i_byte_value;
            end
            REQ_CURSOR: begin
                n_job.value = {1'b1, i_row[0], 2'b00, i_col[3:0]};
            end
            REQ_CLEAR: begin
                n_job.is_clear = 1'b1;
                n_job.value    = CMD_CLEAR_BYTE;
            end
            REQ_INIT: begin
                n_job.is_init = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = known;
        end else if (i_job_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/clnws_queue.sv =====
// Short job queue between front and back stages.
// Depends on clnws_pkg.
`timescale 1ns / 1ps

module clnws_queue
    import clnws_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/clnws_back.sv =====
// Back stage: expands one job into port states, one per cycle while not stalled by i_ready,
// into an output register. Tracks the port latch. Depends on clnws_pkg.
`timescale 1ns / 1ps

module clnws_back
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_port_value,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_PULSE = 2'd1;
    localparam logic [1:0] PH_BYTE  = 2'd2;

    logic        r_busy;
    logic [1:0]  r_phase;
    logic [1:0]  r_idx;
    logic [2:0]  r_sub;
    t_job        r_job;
    logic [7:0]  r_latch;
    logic        r_out_valid;
    logic [7:0]  r_port;
    logic [15:0] r_hold;
    logic        r_last;

    logic        adv;
    logic [7:0]  s_port;
    logic [15:0] s_hold;
    logic        s_last;
    logic [7:0]  b_value;
    logic [7:0]  b_base;
    logic [7:0]  b_rs;
    logic [15:0] b_tail;

    assign o_valid      = r_out_valid;
    assign o_port_value = r_port;
    assign o_hold_us    = r_hold;
    assign o_last       = r_last;
    assign o_job_pop    = !r_busy && i_job_valid;
    assign adv          = r_busy && (!r_out_valid || i_ready);

    always_comb begin
        b_value = r_job.is_init ? init_byte(r_idx) : r_job.value;
        b_rs    = (!r_job.is_init && r_job.is_data) ? RS_BIT : 8'h00;
        b_tail  = (!r_job.is_init && r_job.is_clear) ? HOLD_CLEAR : HOLD_BYTE;
        b_base  = ((r_sub < 3'd3) ? (b_value & NIBBLE_MASK) : {b_value[3:0], 4'h0}) | b_rs;
        s_port  = r_latch;
        s_hold  = HOLD_NONE;
        s_last  = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                s_port = r_latch;
                s_hold = HOLD_LEAD;
            end
            PH_PULSE: begin
                case (r_sub)
                    3'd0: begin
                        s_port = (r_latch & LOW_KEEP) | init_nibble(r_idx);
                    end
                    3'd1: begin
                        s_port = r_latch | E_BIT;
                        s_hold = HOLD_E;
                    end
                    default: begin
                        s_port = r_latch & ~E_BIT;
                        s_hold = init_pulse_tail(r_idx);
                    end
                endcase
            end
            default: begin
                case (r_sub)
                    3'd1, 3'd4: s_port = b_base | E_BIT;
                    default:    s_port = b_base;
                endcase
                if (r_sub == 3'd5) begin
                    s_hold = b_tail;
                    s_last = !r_job.is_init || (r_idx == 2'd3);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_LEAD;
            r_idx       <= '0;
            r_sub       <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy  <= 1'b1;
                r_phase <= i_job.is_init ? PH_LEAD : PH_BYTE;
                r_idx   <= '0;
                r_sub   <= '0;
            end else if (adv) begin
                r_latch <= s_port;
                case (r_phase)
                    PH_LEAD: begin
                        r_phase <= PH_PULSE;
                        r_idx   <= '0;
                        r_sub   <= '0;
                    end
                    PH_PULSE: begin
                        if (r_sub == 3'd2) begin
                            r_sub <= '0;
                            r_idx <= r_idx + 1'b1;
                            if (r_idx == 2'd3) begin
                                r_phase <= PH_BYTE;
                            end
                        end else begin
                            r_sub <= r_sub + 1'b1;
                        end
                    end
                    default: begin
                        if (r_sub == 3'd5) begin
                            r_sub <= '0;
                            r_idx <= r_idx + 1'b1;
                            if (s_last) begin
                                r_busy <= 1'b0;
                            end
                        end else begin
                            r_sub <= r_sub + 1'b1;
                        end
                    end
                endcase
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (adv) begin
            r_port <= s_port;
            r_hold <= s_hold;
            r_last <= s_last;
        end
    end

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// Character LCD 4-bit write sequencer: request words in, port state words out.
// A request passes the front register, queue and back stage before its first port state.
// Throughput: one port state per cycle unless i_ready stalls it; each job is first loaded
// into the back-stage job register; init runs the lead, pulse and byte phases in order.
// Synchronous active-low reset empties the queue and clears the port latch to zero.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_port_value,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    logic f_valid;
    logic q_full;
    logic q_empty;
    logic b_pop;
    t_job f_job;
    t_job q_job;

    clnws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_job_valid  (f_valid),
        .i_job_ready  (!q_full),
        .o_job        (f_job)
    );

    clnws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_full  (q_full),
        .i_job   (f_job),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    clnws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!q_empty),
        .o_job_pop    (b_pop),
        .i_job        (q_job),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_port_value (o_port_value),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

endmodule
